[hdl/sat_pkg.sv]
package sat_pkg;

    // Request type codes
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_FWD  = 2'd1;
    localparam logic [1:0] REQ_REV  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 2'd2;

    localparam logic [63:0] MISS_VALUE = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  section_index;
        logic [31:0] section_virt_start;
        logic [31:0] section_raw_offset;
        logic [31:0] section_raw_size;
        logic [63:0] lookup_address;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [63:0] translated_address;
    } out_word_t;

    // One section table entry
    typedef struct packed {
        logic [31:0] virt;
        logic [31:0] raw_off;
        logic [31:0] raw_size;
    } sect_entry_t;

    // Result selection for the output word
    typedef enum logic [1:0] {
        RES_LOAD,
        RES_MISS,
        RES_HIT
    } res_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     capture;
        logic     load_wr;
        logic     fwd_chk;
        logic     scan_rd;
        logic     hit_cap;
        logic     sum;
        logic     out_load;
        res_sel_t sel;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_image;
        logic more;
        logic cmpv;
        logic hit;
    } dp_status_t;

endpackage

[hdl/sat_datapath.sv]
module sat_datapath #(
    parameter int MAX_SECTIONS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sat_pkg::in_word_t                  in_data,
    input  logic                               cfg_valid,
    input  logic [sat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [63:0]                        cfg_data,
    input  sat_pkg::dp_cmd_t                   cmd,
    output sat_pkg::dp_status_t                status,
    output sat_pkg::out_word_t                 out_data
);

    localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int CMP_W = CNT_W + 6;

    // Configuration registers
    logic [63:0] pref_base_reg;
    logic [31:0] image_size_reg;
    logic [4:0]  section_count_reg;

    // Section table
    sat_pkg::sect_entry_t sect_mem [MAX_SECTIONS];

    // Request and scan registers
    logic              fwd_reg;
    logic              idx_ok_reg;
    logic [63:0]       addr_reg;
    logic [31:0]       key_reg;
    logic [CNT_W-1:0]  ptr_reg;
    logic              cmpv_reg;
    sat_pkg::sect_entry_t entry_reg;
    logic [31:0]       diff_reg;
    logic [31:0]       oper_reg;
    logic [32:0]       sum_reg;
    sat_pkg::out_word_t out_reg;

    logic              idx_ok;
    logic [63:0]       rel;
    logic              in_image;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  lim;
    logic [31:0]       lo;
    logic [31:0]       diff;
    logic              match;
    sat_pkg::out_word_t out_next;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pref_base_reg     <= '0;
            image_size_reg    <= '0;
            section_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sat_pkg::CFG_IMAGE_BASE:    pref_base_reg     <= cfg_data;
                sat_pkg::CFG_IMAGE_SIZE:    image_size_reg    <= cfg_data[31:0];
                sat_pkg::CFG_SECTION_COUNT: section_count_reg <= cfg_data[4:0];
                default:                    ;
            endcase
        end
    end

    // Check the load index against the table depth
    assign idx_ok = CMP_W'(in_data.section_index) < CMP_W'(MAX_SECTIONS);

    // Write the section table on load, read one entry per scan step
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && idx_ok)
        begin
            sect_mem[IDX_W'(in_data.section_index)] <= '{
                virt:     in_data.section_virt_start,
                raw_off:  in_data.section_raw_offset,
                raw_size: in_data.section_raw_size
            };
        end
        if (cmd.scan_rd)
        begin
            entry_reg <= sect_mem[ptr_reg[IDX_W-1:0]];
        end
    end

    // Image bounds check on the captured virtual address
    assign rel      = addr_reg - pref_base_reg;
    assign in_image = (addr_reg >= pref_base_reg) && (rel < {32'd0, image_size_reg});

    // Limit the search to the table depth
    assign cnt_ext = CMP_W'(section_count_reg);
    assign lim     = (cnt_ext < CMP_W'(MAX_SECTIONS)) ? cnt_ext : CMP_W'(MAX_SECTIONS);

    // Compare the key against the half-open range of the read entry
    assign lo    = fwd_reg ? entry_reg.virt : entry_reg.raw_off;
    assign diff  = key_reg - lo;
    assign match = (key_reg >= lo) && (diff < entry_reg.raw_size);

    assign status.in_image = in_image;
    assign status.more     = CMP_W'(ptr_reg) < lim;
    assign status.cmpv     = cmpv_reg;
    assign status.hit      = cmpv_reg && match;

    // Capture the request and advance the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            cmpv_reg <= 1'b0;
        end
        else
        begin
            cmpv_reg <= cmd.scan_rd;
            if (cmd.capture)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
        end
    end

    // Hold request payload and intermediate sums
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            fwd_reg    <= (in_data.req_type == sat_pkg::REQ_FWD);
            idx_ok_reg <= idx_ok;
            addr_reg   <= in_data.lookup_address;
            key_reg    <= in_data.lookup_address[31:0];
        end
        if (cmd.fwd_chk)
        begin
            key_reg <= rel[31:0];
        end
        if (cmd.hit_cap)
        begin
            diff_reg <= diff;
            oper_reg <= fwd_reg ? entry_reg.raw_off : entry_reg.virt;
        end
        if (cmd.sum)
        begin
            sum_reg <= 33'(diff_reg) + 33'(oper_reg);
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    // Form the output word
    always_comb
    begin
        out_next.found              = 1'b0;
        out_next.translated_address = sat_pkg::MISS_VALUE;
        case (cmd.sel)
            sat_pkg::RES_LOAD:
            begin
                out_next.found              = idx_ok_reg;
                out_next.translated_address = '0;
            end
            sat_pkg::RES_HIT:
            begin
                out_next.found = 1'b1;
                if (fwd_reg)
                begin
                    out_next.translated_address = {32'd0, sum_reg[31:0]};
                end
                else
                begin
                    out_next.translated_address = pref_base_reg + 64'(sum_reg);
                end
            end
            default:
            begin
                out_next.found              = 1'b0;
                out_next.translated_address = sat_pkg::MISS_VALUE;
            end
        endcase
    end

    assign out_data = out_reg;

endmodule

[hdl/sat_ctrl.sv]
module sat_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    output logic                out_valid,
    input  logic                out_ready,
    input  sat_pkg::dp_status_t status,
    output sat_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_SUM   = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    sat_pkg::res_sel_t sel_reg;
    sat_pkg::res_sel_t sel_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= sat_pkg::RES_MISS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Sequence one request
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.sel        = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (req_type)
                        sat_pkg::REQ_LOAD:
                        begin
                            cmd.load_wr = 1'b1;
                            sel_next    = sat_pkg::RES_LOAD;
                            state_next  = ST_WRITE;
                        end
                        sat_pkg::REQ_FWD:
                        begin
                            state_next = ST_CHECK;
                        end
                        sat_pkg::REQ_REV:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            sel_next   = sat_pkg::RES_MISS;
                            state_next = ST_WRITE;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                cmd.fwd_chk = 1'b1;
                if (status.in_image)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    sel_next   = sat_pkg::RES_MISS;
                    state_next = ST_WRITE;
                end
            end
            ST_SCAN:
            begin
                if (status.hit)
                begin
                    cmd.hit_cap = 1'b1;
                    state_next  = ST_SUM;
                end
                else if (status.more)
                begin
                    cmd.scan_rd = 1'b1;
                end
                else if (!status.cmpv)
                begin
                    sel_next   = sat_pkg::RES_MISS;
                    state_next = ST_WRITE;
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                sel_next   = sat_pkg::RES_HIT;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A compare hit needs an entry read in the previous cycle
    a_hit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        status.hit |-> status.cmpv)
        else $error("hit without a pending table read");

    // Never overwrite a word that still waits at the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten");

    // An accepted word moves the controller out of idle
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted word left controller idle");

    // Table reads only happen inside the scan and below the limit
    a_scan_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> ((state_reg == ST_SCAN) && status.more))
        else $error("table read outside scan");
`endif

endmodule

[hdl/section_address_translator_core.sv]
// Translates between virtual addresses and file offsets of a sectioned image.
// A load word (type 0) writes one entry of the section table and answers at
// once; a forward word (type 1) checks the address against the preferred load
// base and image_size and then searches the table from entry 0 for the first
// section whose half-open range holds the relative address; a reverse word
// (type 2) searches the raw ranges for the file offset. A miss answers found=0
// with 4294967295. The table is a single-port memory read one entry per cycle
// during a search. A forward word passes CHECK, SCAN, SUM and WRITE in order;
// a reverse word skips CHECK (no image check). A search runs over the smaller
// of section_count and MAX_SECTIONS entries; a miss goes from SCAN straight to
// WRITE. A forward address outside the image goes from CHECK to WRITE, and a
// load or an unused type goes straight to WRITE. WRITE holds until the last
// result is taken. The next word is accepted the cycle after the output
// register loads. One word is in flight at a time; a new word is accepted
// while the previous result still waits at the output.
// Table entries are undefined until loaded. Configuration writes are taken in
// any cycle and must only be issued while the block is idle.
module section_address_translator_core #(
    parameter int MAX_SECTIONS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sat_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sat_pkg::out_word_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);

    sat_pkg::dp_cmd_t    cmd;
    sat_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    sat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (in_data.req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sat_datapath #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule
